// ===== hw/rtl/tas_pkg.sv =====
// ----------------------------------------------------------------------------
// Tardos accusation score package
// Widths and fixed-point constants shared by the accusation score block.
// ----------------------------------------------------------------------------
`default_nettype none

package tas_pkg;

	localparam int BIAS_W    = 16;
	localparam int THRESH_W  = 47;
	localparam int ROOT_FRAC = 16;
	localparam int DIV_SHIFT = 2 * ROOT_FRAC;

endpackage

`default_nettype wire

// ===== hw/rtl/tardos_accusation_score.sv =====
// ----------------------------------------------------------------------------
// Tardos accusation score
// Symmetric Tardos accusation sum for one user with a saturating accumulator.
// ----------------------------------------------------------------------------
// Each input request is one code position: pirate bit, user bit, column bias
// in Q0.16 and a last flag. The block computes the position weight as
// floor(sqrt(ratio) * 2^16), adds it with the proper sign to a saturating
// Q.16 accumulator, and on the last position issues one output request with
// the score and the accusation decision before clearing the accumulator.
// A position takes BIAS_FRAC_BITS + 32 restoring division steps and then
// (BIAS_FRAC_BITS + 33) / 2 square root steps on one shared compare-subtract
// unit. in_ready is low while a position is in progress.
// The threshold is written on the cfg channel, which is always ready.
// Reset clears the accumulator, the threshold and any pending output.
// A finished score waits in the output register while the next positions are
// taken; if a second last position finishes while out_ready is still low,
// the block holds that score and stalls the input until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module tardos_accusation_score
	import tas_pkg::*;
#(
	parameter int SCORE_WIDTH    = 48,
	parameter int BIAS_FRAC_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [THRESH_W-1:0]    cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   pirate_bit,
	input  wire logic                   user_bit,
	input  wire logic [BIAS_W-1:0]      column_bias,
	input  wire logic                   last_position,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [SCORE_WIDTH-1:0]      score,
	output logic                        accused
);

	localparam int BFB   = BIAS_FRAC_BITS;
	localparam int RW    = (BFB + DIV_SHIFT + 1) / 2;
	localparam int CMP_W = (SCORE_WIDTH > THRESH_W) ? SCORE_WIDTH : THRESH_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	localparam logic [SCORE_WIDTH-1:0] SMAX = {1'b0, {(SCORE_WIDTH - 1){1'b1}}};
	localparam logic [SCORE_WIDTH-1:0] SMIN = {1'b1, {(SCORE_WIDTH - 1){1'b0}}};

	logic [1:0]             st_q;
	logic                   neg_q;
	logic                   last_q;
	logic [SCORE_WIDTH-1:0] sum_q;
	logic [THRESH_W-1:0]    thr_q;
	logic                   out_valid_q;
	logic [SCORE_WIDTH-1:0] score_q;
	logic                   accused_q;

	logic [BFB+BIAS_W-1:0]  bias_ext;
	logic [BFB-1:0]         p_raw;
	logic [BFB-1:0]         p_val;
	logic [BFB-1:0]         q_val;
	logic                   w_start;
	logic                   w_done;
	logic [RW-1:0]          w_weight;

	logic [SCORE_WIDTH:0]   t_mag;
	logic [SCORE_WIDTH:0]   t_val;
	logic [SCORE_WIDTH:0]   add;
	logic [SCORE_WIDTH-1:0] new_sum;
	logic [SCORE_WIDTH-1:0] fin_sum;
	logic signed [CMP_W-1:0] s_ext;
	logic signed [CMP_W-1:0] t_ext;
	logic                   out_free;
	logic                   load_out;

	assign bias_ext = {{BFB{1'b0}}, column_bias};
	assign p_raw    = bias_ext[BFB-1:0];
	assign p_val    = (p_raw == '0) ? BFB'(1) : p_raw;
	assign q_val    = '0 - p_val;

	assign in_ready  = (st_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign w_start   = in_valid && in_ready;

	tas_weight #(
		.BFB(BFB)
	) u_weight (
		.clk   (clk),
		.arst_n(arst_n),
		.start (w_start),
		.num   (pirate_bit ? q_val : p_val),
		.den   (pirate_bit ? p_val : q_val),
		.done  (w_done),
		.weight(w_weight)
	);

	assign t_mag = (SCORE_WIDTH + 1)'(w_weight);
	assign t_val = neg_q ? (~t_mag + 1'b1) : t_mag;
	assign add   = {sum_q[SCORE_WIDTH-1], sum_q} + t_val;

	always_comb begin
		if (add[SCORE_WIDTH] != add[SCORE_WIDTH-1]) begin
			new_sum = add[SCORE_WIDTH] ? SMIN : SMAX;
		end else begin
			new_sum = add[SCORE_WIDTH-1:0];
		end
	end

	assign fin_sum  = (st_q == ST_HOLD) ? sum_q : new_sum;
	assign s_ext    = CMP_W'($signed(fin_sum));
	assign t_ext    = CMP_W'(thr_q);
	assign out_free = !out_valid_q || out_ready;
	assign load_out = ((st_q == ST_BUSY) && w_done && last_q && out_free) ||
		((st_q == ST_HOLD) && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			neg_q       <= 1'b0;
			last_q      <= 1'b0;
			sum_q       <= '0;
			thr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						neg_q  <= pirate_bit ^ user_bit;
						last_q <= last_position;
						st_q   <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (w_done) begin
						if (!last_q) begin
							sum_q <= new_sum;
							st_q  <= ST_IDLE;
						end else if (out_free) begin
							sum_q <= '0;
							st_q  <= ST_IDLE;
						end else begin
							sum_q <= new_sum;
							st_q  <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						sum_q <= '0;
						st_q  <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			score_q   <= fin_sum;
			accused_q <= (s_ext >= t_ext);
		end
	end

	assign out_valid = out_valid_q;
	assign score     = score_q;
	assign accused   = accused_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> st_q == ST_BUSY)
		else $error("accepted request did not start a position");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		w_done |-> st_q == ST_BUSY)
		else $error("weight finished with no position in progress");

	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> sum_q == '0 && out_valid_q)
		else $error("score issued without clearing the accumulator");

	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_HOLD |-> out_valid_q)
		else $error("score held while the output register is empty");

endmodule

`default_nettype wire

// ===== hw/rtl/tas_csub.sv =====
// ----------------------------------------------------------------------------
// Shared compare-subtract unit
// Computes a - b and whether a is at least b, for division and root steps.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_csub #(
	parameter int W = 28
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic      [W-1:0] diff,
	output logic              ge
);

	logic borrow;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

`default_nettype wire

// ===== hw/rtl/tas_weight.sv =====
// ----------------------------------------------------------------------------
// Ratio root sequencer
// Computes floor(sqrt(num * 2^32 / den)) with one restoring division step
// and then one square root step per cycle on the shared compare-subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_weight
	import tas_pkg::*;
#(
	parameter int BFB = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [BFB-1:0]                        num,
	input  wire logic [BFB-1:0]                        den,
	output logic                                       done,
	output logic [(BFB+DIV_SHIFT+1)/2-1:0]             weight
);

	localparam int NB    = BFB + DIV_SHIFT;
	localparam int RW    = (NB + 1) / 2;
	localparam int SW    = 2 * RW;
	localparam int UW    = RW + 4;
	localparam int CNT_W = $clog2(NB);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_ROOT = 2'd2;

	logic [1:0]       st_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NB-1:0]    dvd_q;
	logic [BFB-1:0]   den_q;
	logic [SW-1:0]    dq_q;
	logic [RW+1:0]    rem_q;
	logic [RW-1:0]    root_q;
	logic             done_q;

	logic [UW-1:0] u_a;
	logic [UW-1:0] u_b;
	logic [UW-1:0] u_diff;
	logic          u_ge;

	always_comb begin
		if (st_q == S_DIV) begin
			u_a = UW'({rem_q[BFB-1:0], dvd_q[NB-1]});
			u_b = UW'(den_q);
		end else begin
			u_a = UW'({rem_q, dq_q[SW-1 -: 2]});
			u_b = UW'({root_q, 2'b01});
		end
	end

	tas_csub #(
		.W(UW)
	) u_csub (
		.a   (u_a),
		.b   (u_b),
		.diff(u_diff),
		.ge  (u_ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						st_q  <= S_DIV;
						cnt_q <= CNT_W'(NB - 1);
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						st_q  <= S_ROOT;
						cnt_q <= CNT_W'(RW - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_ROOT: begin
					if (cnt_q == '0) begin
						st_q   <= S_IDLE;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				if (start) begin
					dvd_q  <= {num, {DIV_SHIFT{1'b0}}};
					den_q  <= den;
					dq_q   <= '0;
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			S_DIV: begin
				dvd_q <= dvd_q << 1;
				dq_q  <= {dq_q[SW-2:0], u_ge};
				if (cnt_q == '0) begin
					rem_q <= '0;
				end else if (u_ge) begin
					rem_q <= (RW + 2)'(u_diff[BFB-1:0]);
				end else begin
					rem_q <= (RW + 2)'(u_a[BFB-1:0]);
				end
			end
			S_ROOT: begin
				dq_q   <= dq_q << 2;
				root_q <= {root_q[RW-2:0], u_ge};
				rem_q  <= u_ge ? u_diff[RW+1:0] : u_a[RW+1:0];
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign weight = root_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == S_IDLE)
		else $error("sequencer started while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> st_q == S_IDLE && $past(st_q) == S_ROOT)
		else $error("done raised outside root completion");

endmodule

`default_nettype wire
